// File: src/can_rx_supervisor_macros.svh
// ---------------------------------------------------------------------------
// CAN receive supervisor assertion macros
// Shared property templates for the port checker.
// ---------------------------------------------------------------------------
`ifndef CAN_RX_SUPERVISOR_MACROS_SVH
`define CAN_RX_SUPERVISOR_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define CRS_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define CRS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/crs_pkg.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor package
// Payload types, command format, codes and small helpers.
// ---------------------------------------------------------------------------
package crs_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_ERROR   = 2'd2;
  localparam logic [1:0] OP_TX_FAIL = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STUCK_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_ERROR_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  STUCK_LIMIT_RST   = 8'd5;
  localparam logic [7:0]  ERROR_LIMIT_RST   = 8'd20;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd200;

  // Identifiers of interest.
  localparam logic [10:0] ID_MOTOR_ERR = 11'h001;
  localparam logic [10:0] ID_EMERGENCY = 11'h002;
  localparam logic [10:0] ID_STATUS    = 11'h004;
  localparam logic [10:0] ID_OWN_ACCEL = 11'h012;

  // Node state codes.
  localparam logic [7:0] ST_OFF          = 8'h01;
  localparam logic [7:0] ST_READY        = 8'h02;
  localparam logic [7:0] ST_DRIVE        = 8'h04;
  localparam logic [7:0] ST_EMERGENCY    = 8'h08;
  localparam logic [7:0] ST_MOTOR_ERR    = 8'h10;
  localparam logic [7:0] ST_CENTRAL_DOWN = 8'h20;
  localparam logic [7:0] ST_BROKEN_SELF  = 8'h40;

  // LED command codes.
  localparam logic [7:0] LAMP_READY        = 8'h01;
  localparam logic [7:0] LAMP_EMERGENCY    = 8'h02;
  localparam logic [7:0] LAMP_CENTRAL_DOWN = 8'h04;
  localparam logic [7:0] LAMP_BROKEN_SELF  = 8'h08;
  localparam logic [7:0] LAMP_ALL_OFF      = 8'hFF;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] frame_id;
    logic        frame_extended;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic        bus_off_flag;
    logic        ack_error_flag;
    logic        overrun_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] node_state_out;
    logic [7:0] lamp_cmd;
    logic       can_stopped;
    logic       checksum_bad;
    logic       stuck_seen;
    logic [7:0] error_count_out;
  } out_item_t;

  // Work kinds handed from the classifier to the state update.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_BAD_FRAME,
    CMD_CENTRAL,
    CMD_TICK,
    CMD_ERROR,
    CMD_TX_FAIL
  } cmd_kind_e;

  typedef enum logic [2:0] {
    IDC_OTHER,
    IDC_MOTOR,
    IDC_EMERG,
    IDC_STATUS,
    IDC_ACCEL
  } id_cls_e;

  typedef struct packed {
    cmd_kind_e  kind;
    id_cls_e    cls;
    logic       len_is_8;
    logic [7:0] byte0;
    logic [7:0] byte6;
    logic       bus_off;
    logic       ack_err;
    logic       err_none;
    logic       cks_bad;
  } cmd_t;

  // LED command shown for a node state.
  function automatic logic [7:0] led_for(input logic [7:0] s);
    logic [7:0] led;
    unique case (s)
      ST_READY:                      led = LAMP_READY;
      ST_EMERGENCY:                  led = LAMP_EMERGENCY;
      ST_MOTOR_ERR, ST_CENTRAL_DOWN: led = LAMP_CENTRAL_DOWN;
      ST_BROKEN_SELF:                led = LAMP_BROKEN_SELF;
      default:                       led = LAMP_ALL_OFF;
    endcase
    return led;
  endfunction

  // The node stops its CAN activity in the fault states.
  function automatic logic stopped_for(input logic [7:0] s);
    return (s == ST_MOTOR_ERR) || (s == ST_CENTRAL_DOWN) || (s == ST_BROKEN_SELF);
  endfunction

endpackage

// File: src/crs_front.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor front end
// Accepts input items, checks the frame checksum and classifies the work.
// ---------------------------------------------------------------------------
module crs_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crs_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output crs_pkg::cmd_t     cmd_o
);

  logic [7:0]       sum;
  logic [7:0]       byte7;
  logic             sum_bad;
  crs_pkg::id_cls_e cls;

  // Take an item whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Additive checksum over bytes 0 to 6.
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < 7; i++) begin
      sum = sum + in_item_i.frame_payload[8*i +: 8];
    end
  end

  assign byte7   = in_item_i.frame_payload[63:56];
  assign sum_bad = (sum != byte7);

  // Identifier class.
  always_comb begin
    unique case (in_item_i.frame_id)
      crs_pkg::ID_MOTOR_ERR: cls = crs_pkg::IDC_MOTOR;
      crs_pkg::ID_EMERGENCY: cls = crs_pkg::IDC_EMERG;
      crs_pkg::ID_STATUS:    cls = crs_pkg::IDC_STATUS;
      crs_pkg::ID_OWN_ACCEL: cls = crs_pkg::IDC_ACCEL;
      default:               cls = crs_pkg::IDC_OTHER;
    endcase
  end

  // Build the command for the back end.
  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = crs_pkg::CMD_NONE;
    cmd_o.cls      = cls;
    cmd_o.len_is_8 = (in_item_i.frame_length == 4'd8);
    cmd_o.byte0    = in_item_i.frame_payload[7:0];
    cmd_o.byte6    = in_item_i.frame_payload[55:48];
    cmd_o.bus_off  = in_item_i.bus_off_flag;
    cmd_o.ack_err  = in_item_i.ack_error_flag;
    cmd_o.err_none = !in_item_i.bus_off_flag && !in_item_i.ack_error_flag &&
                     !in_item_i.overrun_flag;
    cmd_o.cks_bad  = 1'b0;
    unique case (in_item_i.op)
      crs_pkg::OP_FRAME: begin
        // Extended frames are dropped without effect.
        if (!in_item_i.frame_extended) begin
          if (sum_bad) begin
            cmd_o.kind    = crs_pkg::CMD_BAD_FRAME;
            cmd_o.cks_bad = 1'b1;
          end else if (cls == crs_pkg::IDC_MOTOR || cls == crs_pkg::IDC_EMERG ||
                       cls == crs_pkg::IDC_STATUS) begin
            cmd_o.kind = crs_pkg::CMD_CENTRAL;
          end
        end
      end
      crs_pkg::OP_TICK:    cmd_o.kind = crs_pkg::CMD_TICK;
      crs_pkg::OP_ERROR:   cmd_o.kind = crs_pkg::CMD_ERROR;
      crs_pkg::OP_TX_FAIL: cmd_o.kind = crs_pkg::CMD_TX_FAIL;
      default:             cmd_o.kind = crs_pkg::CMD_NONE;
    endcase
  end

endmodule

// File: src/crs_queue.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor command queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
module crs_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  crs_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output crs_pkg::cmd_t cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  crs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: src/crs_back.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor back end
// Updates the node state from queued commands and registers each result.
// ---------------------------------------------------------------------------
module crs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               q_empty_i,
  input  crs_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crs_pkg::out_item_t out_item_o
);

  logic [7:0]  stuck_limit_q;
  logic [7:0]  error_limit_q;
  logic [15:0] timeout_ticks_q;

  logic [7:0]  state_q, state_d;
  logic [7:0]  last_roll_q, last_roll_d;
  logic [7:0]  repeat_q, repeat_d;
  logic [7:0]  err_cnt_q, err_cnt_d;
  // Ticks since the last valid central frame, modulo 2^32.
  logic [31:0] elapsed_q, elapsed_d;

  logic        out_valid_q;
  crs_pkg::out_item_t out_q;

  logic [7:0]  err_inc;
  logic [7:0]  rep_inc;
  logic [31:0] elapsed_inc;
  logic        stuck;
  logic        heartbeat_state;

  // A command leaves the queue when the output register is free or being taken.
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  assign err_inc     = (err_cnt_q == crs_pkg::COUNT_MAX) ? err_cnt_q : err_cnt_q + 8'd1;
  assign rep_inc     = (repeat_q == crs_pkg::COUNT_MAX) ? repeat_q : repeat_q + 8'd1;
  assign elapsed_inc = elapsed_q + 32'd1;
  assign heartbeat_state = (state_q == crs_pkg::ST_READY) || (state_q == crs_pkg::ST_DRIVE) ||
                           (state_q == crs_pkg::ST_EMERGENCY) ||
                           (state_q == crs_pkg::ST_MOTOR_ERR);

  // Node state update for one command.
  always_comb begin
    state_d     = state_q;
    last_roll_d = last_roll_q;
    repeat_d    = repeat_q;
    err_cnt_d   = err_cnt_q;
    elapsed_d   = elapsed_q;
    stuck       = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.kind)
        crs_pkg::CMD_NONE: begin
        end
        crs_pkg::CMD_BAD_FRAME: begin
          if (cmd_i.cls == crs_pkg::IDC_STATUS) begin
            err_cnt_d = err_inc;
            if (err_inc >= error_limit_q) begin
              state_d = crs_pkg::ST_CENTRAL_DOWN;
            end
          end
        end
        crs_pkg::CMD_CENTRAL: begin
          // Rolling counter history shared by all central identifiers.
          if (cmd_i.byte6 == last_roll_q) begin
            repeat_d = rep_inc;
            stuck    = (rep_inc > stuck_limit_q);
          end else begin
            repeat_d    = 8'd0;
            last_roll_d = cmd_i.byte6;
          end
          if (stuck) begin
            if (cmd_i.cls == crs_pkg::IDC_STATUS) begin
              err_cnt_d = err_inc;
              if (err_inc >= error_limit_q) begin
                state_d = crs_pkg::ST_CENTRAL_DOWN;
              end
            end
          end else begin
            if (cmd_i.cls == crs_pkg::IDC_MOTOR) begin
              state_d = crs_pkg::ST_MOTOR_ERR;
            end else if (cmd_i.cls == crs_pkg::IDC_EMERG) begin
              state_d = crs_pkg::ST_EMERGENCY;
            end else if (cmd_i.len_is_8) begin
              state_d = cmd_i.byte0;
            end
            err_cnt_d = 8'd0;
            elapsed_d = 32'd0;
          end
        end
        crs_pkg::CMD_TICK: begin
          elapsed_d = elapsed_inc;
          if (heartbeat_state && (elapsed_inc > {16'd0, timeout_ticks_q})) begin
            state_d = crs_pkg::ST_CENTRAL_DOWN;
          end
        end
        crs_pkg::CMD_ERROR: begin
          if (cmd_i.bus_off || cmd_i.err_none) begin
            state_d = crs_pkg::ST_BROKEN_SELF;
          end
          if (cmd_i.ack_err) begin
            err_cnt_d = err_inc;
          end
        end
        crs_pkg::CMD_TX_FAIL: begin
          if (cmd_i.cls == crs_pkg::IDC_ACCEL) begin
            state_d = crs_pkg::ST_BROKEN_SELF;
          end else if (cmd_i.cls == crs_pkg::IDC_STATUS) begin
            err_cnt_d = err_inc;
            if (err_inc >= error_limit_q) begin
              state_d = crs_pkg::ST_CENTRAL_DOWN;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and supervision state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stuck_limit_q   <= crs_pkg::STUCK_LIMIT_RST;
      error_limit_q   <= crs_pkg::ERROR_LIMIT_RST;
      timeout_ticks_q <= crs_pkg::TIMEOUT_TICKS_RST;
      state_q         <= crs_pkg::ST_OFF;
      last_roll_q     <= 8'd0;
      repeat_q        <= 8'd0;
      err_cnt_q       <= 8'd0;
      elapsed_q       <= 32'd0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          crs_pkg::CFG_STUCK_LIMIT:   stuck_limit_q   <= cfg_wdata_i[7:0];
          crs_pkg::CFG_ERROR_LIMIT:   error_limit_q   <= cfg_wdata_i[7:0];
          crs_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      last_roll_q <= last_roll_d;
      repeat_q    <= repeat_d;
      err_cnt_q   <= err_cnt_d;
      elapsed_q   <= elapsed_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register, loaded with the state after the update.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.node_state_out  <= state_d;
      out_q.lamp_cmd        <= crs_pkg::led_for(state_d);
      out_q.can_stopped     <= crs_pkg::stopped_for(state_d);
      out_q.checksum_bad    <= cmd_i.cks_bad;
      out_q.stuck_seen      <= stuck;
      out_q.error_count_out <= err_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/can_rx_supervisor.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor
// Node state keeping and checking of received CAN frames, ticks and events.
// ---------------------------------------------------------------------------
// Each accepted item (frame, tick, error event or transmit failure) yields
// exactly one result carrying the node state after the update, the LED
// command, the CAN-stop flag, the checksum and stuck-counter verdicts and the
// central error count. The block sustains one item per clock cycle while the output
// side does not stall; each command passes through the command queue, and the
// combinational state update loads the output register when the command is
// popped, which waits while the output side stalls. The queue holds
// QueueDepth commands, so the input side keeps accepting while a result
// waits. Configuration writes must be issued only while no item is in
// flight.
module can_rx_supervisor #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  crs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crs_pkg::out_item_t out_item_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  crs_pkg::cmd_t front_cmd;
  crs_pkg::cmd_t back_cmd;

  // Classification of incoming items.
  crs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // Command queue between the two halves.
  crs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (back_cmd)
  );

  // State update and result register.
  crs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: src/crs_checker.sv
// ---------------------------------------------------------------------------
// CAN receive supervisor port checker
// Assertions on the top-level ports, attached by bind.
// ---------------------------------------------------------------------------
`include "can_rx_supervisor_macros.svh"

module crs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input crs_pkg::out_item_t out_item_o
);

  logic               state_stops;
  logic               stalled;
  crs_pkg::out_item_t res;
  logic               stop_ok;
  logic               lamp_ok;
  logic               one_verdict;

  assign state_stops = (out_item_o.node_state_out == crs_pkg::ST_MOTOR_ERR) ||
                       (out_item_o.node_state_out == crs_pkg::ST_CENTRAL_DOWN) ||
                       (out_item_o.node_state_out == crs_pkg::ST_BROKEN_SELF);

  assign stalled     = out_valid_o && out_stall_i;
  assign res         = out_item_o;
  assign stop_ok     = (out_item_o.can_stopped == state_stops);
  assign lamp_ok     = (out_item_o.lamp_cmd == crs_pkg::led_for(out_item_o.node_state_out));
  assign one_verdict = !(out_item_o.checksum_bad && out_item_o.stuck_seen);

  // A stalled result stays offered and unchanged.
  `CRS_ASSERT_NEXT(a_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(res), "result not held")

  // The stop flag follows the reported state.
  `CRS_ASSERT_NOW(a_stop_match, clk_i, rst_ni, out_valid_o, stop_ok, "stop flag wrong")

  // The LED command follows the reported state.
  `CRS_ASSERT_NOW(a_lamp_match, clk_i, rst_ni, out_valid_o, lamp_ok, "lamp command wrong")

  // A frame is never both a checksum failure and a stuck rejection.
  `CRS_ASSERT_NOW(a_one_verdict, clk_i, rst_ni, out_valid_o, one_verdict, "both verdicts set")

endmodule

bind can_rx_supervisor crs_checker u_crs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// File: sim/can_rx_supervisor_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CAN receive supervisor testbench
// Drives frames, ticks, error events and transmit failures through the
// valid/stall input channel under several register settings and idle
// patterns. A behavioral copy of the supervisor predicts each result, and the
// monitor compares every output transfer field by field against the oldest
// prediction.
// ---------------------------------------------------------------------------
module can_rx_supervisor_tb;

  // Ports of the block.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = crs_pkg::CFG_STUCK_LIMIT;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  crs_pkg::in_item_t  in_item_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  crs_pkg::out_item_t out_item_o;

  // Stimulus, expectations and run control.
  crs_pkg::in_item_t  pending_items_q[$];
  crs_pkg::out_item_t expected_status_q[$];
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 mismatch_count = 0;
  logic [7:0]         tx_roll = '0;

  // Supervisor state as predicted by the testbench.
  logic [7:0]  pred_stuck_limit = crs_pkg::STUCK_LIMIT_RST;
  logic [7:0]  pred_error_limit = crs_pkg::ERROR_LIMIT_RST;
  logic [15:0] pred_timeout     = crs_pkg::TIMEOUT_TICKS_RST;
  logic [7:0]  pred_state       = crs_pkg::ST_OFF;
  logic [7:0]  pred_last_roll   = '0;
  logic [7:0]  pred_repeats     = '0;
  logic [7:0]  pred_err_count   = '0;
  logic [31:0] pred_now         = '0;
  logic [31:0] pred_heard       = '0;

  can_rx_supervisor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Additive checksum over payload bytes 0 to 6.
  function automatic logic [7:0] byte_sum7(input logic [63:0] pl);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 7; k++) acc += pl[8*k +: 8];
    return acc;
  endfunction

  function automatic logic [7:0] status_led(input logic [7:0] s);
    logic [7:0] led;
    case (s)
      crs_pkg::ST_READY:        led = crs_pkg::LAMP_READY;
      crs_pkg::ST_EMERGENCY:    led = crs_pkg::LAMP_EMERGENCY;
      crs_pkg::ST_MOTOR_ERR:    led = crs_pkg::LAMP_CENTRAL_DOWN;
      crs_pkg::ST_CENTRAL_DOWN: led = crs_pkg::LAMP_CENTRAL_DOWN;
      crs_pkg::ST_BROKEN_SELF:  led = crs_pkg::LAMP_BROKEN_SELF;
      default:                  led = crs_pkg::LAMP_ALL_OFF;
    endcase
    return led;
  endfunction

  // Saturating increment of the central error count, optionally checked
  // against the limit that declares the central controller down.
  function automatic void bump_error_count(input logic check_limit);
    if (pred_err_count != crs_pkg::COUNT_MAX) pred_err_count++;
    if (check_limit && pred_err_count >= pred_error_limit) begin
      pred_state = crs_pkg::ST_CENTRAL_DOWN;
    end
  endfunction

  // Update the predicted supervisor with one item and form its result.
  task automatic supervise(input crs_pkg::in_item_t it, output crs_pkg::out_item_t res);
    logic [7:0]  b6;
    logic [31:0] since_heard;
    logic        bad;
    logic        stuck;
    logic        central;
    bad     = 1'b0;
    stuck   = 1'b0;
    b6      = it.frame_payload[55:48];
    central = (it.frame_id == crs_pkg::ID_MOTOR_ERR) ||
              (it.frame_id == crs_pkg::ID_EMERGENCY) ||
              (it.frame_id == crs_pkg::ID_STATUS);
    case (it.op)
      crs_pkg::OP_FRAME: begin
        if (!it.frame_extended) begin
          if (byte_sum7(it.frame_payload) != it.frame_payload[63:56]) begin
            bad = 1'b1;
            if (it.frame_id == crs_pkg::ID_STATUS) bump_error_count(1'b1);
          end else if (central) begin
            // Shared rolling-counter history across the central identifiers.
            if (b6 == pred_last_roll) begin
              if (pred_repeats != crs_pkg::COUNT_MAX) pred_repeats++;
              stuck = (pred_repeats > pred_stuck_limit);
            end else begin
              pred_repeats   = '0;
              pred_last_roll = b6;
            end
            if (stuck) begin
              if (it.frame_id == crs_pkg::ID_STATUS) bump_error_count(1'b1);
            end else begin
              if (it.frame_id == crs_pkg::ID_MOTOR_ERR) begin
                pred_state = crs_pkg::ST_MOTOR_ERR;
              end else if (it.frame_id == crs_pkg::ID_EMERGENCY) begin
                pred_state = crs_pkg::ST_EMERGENCY;
              end else if (it.frame_length == 4'd8) begin
                pred_state = it.frame_payload[7:0];
              end
              pred_err_count = '0;
              pred_heard     = pred_now;
            end
          end
        end
      end
      crs_pkg::OP_TICK: begin
        pred_now++;
        since_heard = pred_now - pred_heard;
        if ((pred_state == crs_pkg::ST_READY || pred_state == crs_pkg::ST_DRIVE ||
             pred_state == crs_pkg::ST_EMERGENCY || pred_state == crs_pkg::ST_MOTOR_ERR) &&
            since_heard > {16'd0, pred_timeout}) pred_state = crs_pkg::ST_CENTRAL_DOWN;
      end
      crs_pkg::OP_ERROR: begin
        if (it.bus_off_flag) pred_state = crs_pkg::ST_BROKEN_SELF;
        if (it.ack_error_flag) bump_error_count(1'b0);
        if (!it.bus_off_flag && !it.ack_error_flag && !it.overrun_flag) begin
          pred_state = crs_pkg::ST_BROKEN_SELF;
        end
      end
      default: begin
        if (it.frame_id == crs_pkg::ID_OWN_ACCEL) pred_state = crs_pkg::ST_BROKEN_SELF;
        else if (it.frame_id == crs_pkg::ID_STATUS) bump_error_count(1'b1);
      end
    endcase
    res.node_state_out  = pred_state;
    res.lamp_cmd        = status_led(pred_state);
    res.can_stopped     = (pred_state == crs_pkg::ST_MOTOR_ERR) ||
                          (pred_state == crs_pkg::ST_CENTRAL_DOWN) ||
                          (pred_state == crs_pkg::ST_BROKEN_SELF);
    res.checksum_bad    = bad;
    res.stuck_seen      = stuck;
    res.error_count_out = pred_err_count;
  endtask

  // A standard frame with a correct checksum and random filler bytes.
  function automatic crs_pkg::in_item_t checked_frame(input logic [10:0] id,
                                                      input logic [3:0] len,
                                                      input logic [7:0] b0,
                                                      input logic [7:0] roll);
    crs_pkg::in_item_t it;
    it = '0;
    it.op             = crs_pkg::OP_FRAME;
    it.frame_id       = id;
    it.frame_length   = len;
    it.frame_payload  = {$urandom, $urandom};
    it.frame_payload[7:0]   = b0;
    it.frame_payload[55:48] = roll;
    it.frame_payload[63:56] = byte_sum7(it.frame_payload);
    it.bus_off_flag   = 1'($urandom_range(1));
    it.ack_error_flag = 1'($urandom_range(1));
    it.overrun_flag   = 1'($urandom_range(1));
    return it;
  endfunction

  // An item of any operation, with random filler in the fields that non-frame items do not use.
  function automatic crs_pkg::in_item_t plain_item(input logic [1:0] op, input logic [10:0] id,
                                                   input logic bus_off, input logic ack,
                                                   input logic ovr);
    crs_pkg::in_item_t it;
    it.op             = op;
    it.frame_id       = id;
    it.frame_extended = 1'($urandom_range(1));
    it.frame_length   = 4'($urandom_range(15));
    it.frame_payload  = {$urandom, $urandom};
    it.bus_off_flag   = bus_off;
    it.ack_error_flag = ack;
    it.overrun_flag   = ovr;
    return it;
  endfunction

  function automatic logic [7:0] random_state_byte();
    logic [7:0] s;
    case ($urandom_range(7))
      0: s = crs_pkg::ST_OFF;
      1: s = crs_pkg::ST_READY;
      2: s = crs_pkg::ST_DRIVE;
      3: s = crs_pkg::ST_EMERGENCY;
      4: s = crs_pkg::ST_MOTOR_ERR;
      5: s = crs_pkg::ST_CENTRAL_DOWN;
      6: s = crs_pkg::ST_BROKEN_SELF;
      default: s = 8'($urandom_range(255));
    endcase
    return s;
  endfunction

  // Any item with random flags and the given identifier.
  function automatic crs_pkg::in_item_t random_plain(input logic [1:0] op,
                                                     input logic [10:0] id);
    return plain_item(op, id, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
  endfunction

  // Mostly well-formed traffic from the central controller, with noise.
  function automatic crs_pkg::in_item_t random_item();
    crs_pkg::in_item_t it;
    int                pick;
    logic [10:0]       id;
    logic [3:0]        len;
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(19))
        0, 1, 2, 3:               id = crs_pkg::ID_MOTOR_ERR;
        4, 5, 6, 7:               id = crs_pkg::ID_EMERGENCY;
        8, 9, 10, 11, 12, 13, 14: id = crs_pkg::ID_STATUS;
        15, 16:                   id = crs_pkg::ID_OWN_ACCEL;
        default:                  id = 11'($urandom_range(2047));
      endcase
      len = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd8;
      if ($urandom_range(2) != 0) tx_roll++;
      it = checked_frame(id, len, random_state_byte(), tx_roll);
      if ($urandom_range(9) == 0) it.frame_payload[63:56] = 8'($urandom_range(255));
      it.frame_extended = ($urandom_range(9) == 0);
    end else if (pick < 80) begin
      it = random_plain(crs_pkg::OP_TICK, 11'($urandom_range(2047)));
    end else if (pick < 90) begin
      it = random_plain(crs_pkg::OP_ERROR, 11'($urandom_range(2047)));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: id = crs_pkg::ID_STATUS;
        4, 5, 6:    id = crs_pkg::ID_OWN_ACCEL;
        default:    id = 11'($urandom_range(2047));
      endcase
      it = random_plain(crs_pkg::OP_TX_FAIL, id);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Wait until every queued item has been sent and every result checked,
  // then let the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items_q.size() != 0 || in_valid_i || expected_status_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      crs_pkg::CFG_STUCK_LIMIT: pred_stuck_limit = value[7:0];
      crs_pkg::CFG_ERROR_LIMIT: pred_error_limit = value[7:0];
      default:                  pred_timeout     = value;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] stuck, input logic [7:0] err_limit,
                                input logic [15:0] timeout);
    wait_drained();
    write_register(crs_pkg::CFG_STUCK_LIMIT, {8'd0, stuck});
    write_register(crs_pkg::CFG_ERROR_LIMIT, {8'd0, err_limit});
    write_register(crs_pkg::CFG_TIMEOUT_TICKS, timeout);
  endtask

  // Random traffic, now and then a burst of repeated counters or a quiet
  // stretch of ticks long enough to trip the heartbeat timeout.
  task automatic run_random_phase(input int count, input int send_pct, input int stall_pct);
    logic [10:0] id;
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pending_items_q.push_back(random_item());
      if ($urandom_range(99) < 3 && pred_stuck_limit <= 40) begin
        for (int r = 0; r < pred_stuck_limit + 2; r++) begin
          id = ($urandom_range(2) == 0) ? crs_pkg::ID_EMERGENCY : crs_pkg::ID_STATUS;
          pending_items_q.push_back(checked_frame(id, 4'd8, random_state_byte(), tx_roll));
        end
      end
      if ($urandom_range(99) < 1 && pred_timeout <= 60) begin
        for (int r = 0; r < pred_timeout + 2; r++) begin
          pending_items_q.push_back(plain_item(crs_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0));
        end
      end
    end
  endtask

  // Driver: predicts each accepted transfer and presents the next item.
  always @(posedge clk_i) begin : item_driver
    crs_pkg::out_item_t predicted;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        supervise(in_item_i, predicted);
        expected_status_q.push_back(predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= pending_items_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer and stalls the result side at random.
  always @(posedge clk_i) begin : result_monitor
    crs_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("result transfer with no expectation pending");
        end else begin
          want = expected_status_q.pop_front();
          compare_field("node_state_out", out_item_o.node_state_out, want.node_state_out);
          compare_field("lamp_cmd", out_item_o.lamp_cmd, want.lamp_cmd);
          compare_field("can_stopped", {7'd0, out_item_o.can_stopped},
                        {7'd0, want.can_stopped});
          compare_field("checksum_bad", {7'd0, out_item_o.checksum_bad},
                        {7'd0, want.checksum_bad});
          compare_field("stuck_seen", {7'd0, out_item_o.stuck_seen},
                        {7'd0, want.stuck_seen});
          compare_field("error_count_out", out_item_o.error_count_out, want.error_count_out);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    crs_pkg::in_item_t it;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: every operation, length and identifier corner.
    @(negedge clk_i);
    pending_items_q.push_back(plain_item(crs_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY, 8'd1));
    // Repeated counter below the stuck limit is still taken.
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_DRIVE, 8'd1));
    pending_items_q.push_back(checked_frame(crs_pkg::ID_MOTOR_ERR, 4'd8, 8'd0, 8'd2));
    pending_items_q.push_back(checked_frame(crs_pkg::ID_EMERGENCY, 4'd3, 8'd0, 8'd3));
    // Status frames shorter or longer than eight bytes leave the state alone.
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd7, crs_pkg::ST_READY, 8'd4));
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd15, crs_pkg::ST_READY, 8'd5));
    it = checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY, 8'd6);
    it.frame_payload[63:56] ^= 8'h01;
    pending_items_q.push_back(it);
    it = checked_frame(11'h7FF, 4'd8, 8'hFF, 8'hFF);
    it.frame_payload = '1;
    pending_items_q.push_back(it);
    pending_items_q.push_back(checked_frame(11'h7FF, 4'd8, 8'hAA, 8'h55));
    // Extended frames are ignored even when the checksum is wrong.
    it = checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_BROKEN_SELF, 8'd9);
    it.frame_extended = 1'b1;
    it.frame_payload[63:56] ^= 8'h80;
    pending_items_q.push_back(it);
    it = checked_frame(crs_pkg::ID_STATUS, 4'd8, 8'd0, 8'd0);
    it.frame_payload = '0;
    pending_items_q.push_back(it);
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY, 8'd7));
    pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, '0, 1'b1, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, '0, 1'b0, 1'b1, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, '0, 1'b0, 1'b0, 1'b1));
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY, 8'd8));
    // An error event with no flag set marks the node itself as broken.
    pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, '0, 1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, 11'h7FF, 1'b1, 1'b1, 1'b1));
    pending_items_q.push_back(plain_item(crs_pkg::OP_TX_FAIL, crs_pkg::ID_OWN_ACCEL,
                                         1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_TX_FAIL, crs_pkg::ID_STATUS,
                                         1'b1, 1'b1, 1'b1));
    pending_items_q.push_back(plain_item(crs_pkg::OP_TX_FAIL, 11'h7FF, 1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_TX_FAIL, 11'h000, 1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_FRAME, 11'h000, 1'b0, 1'b0, 1'b0));
    pending_items_q.push_back(plain_item(crs_pkg::OP_TICK, '0, 1'b1, 1'b1, 1'b1));
    tx_roll = 8'd8;

    // Random traffic under several settings and idle patterns.
    apply_settings(8'd5, 8'd20, 16'd200);
    run_random_phase(180, 0, 0);
    apply_settings(8'd0, 8'd1, 16'd1);
    run_random_phase(170, 56, 0);
    apply_settings(8'd255, 8'd255, 16'd65535);
    run_random_phase(170, 0, 56);
    apply_settings(8'd2, 8'd3, 16'd10);
    run_random_phase(220, 11, 11);
    apply_settings(8'd1, 8'd255, 16'd50);
    run_random_phase(140, 0, 0);
    // Sender holds off until the block has delivered everything.
    wait_drained();
    run_random_phase(140, 0, 0);

    // Saturation of the repeat and error counters.
    apply_settings(8'd254, 8'd255, 16'd65535);
    @(negedge clk_i);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    tx_roll++;
    pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY,
                                            tx_roll));
    for (int n = 0; n < 260; n++) begin
      case (n % 3)
        0: begin
          pending_items_q.push_back(checked_frame(crs_pkg::ID_MOTOR_ERR, 4'd8, 8'd0, tx_roll));
        end
        1: begin
          pending_items_q.push_back(checked_frame(crs_pkg::ID_EMERGENCY, 4'd8, 8'd0, tx_roll));
        end
        default: begin
          pending_items_q.push_back(checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_DRIVE,
                                                  tx_roll));
        end
      endcase
    end
    for (int n = 0; n < 260; n++) begin
      pending_items_q.push_back(plain_item(crs_pkg::OP_ERROR, '0, 1'b0, 1'b1,
                                           1'($urandom_range(1))));
    end
    it = checked_frame(crs_pkg::ID_STATUS, 4'd8, crs_pkg::ST_READY, tx_roll + 8'd1);
    it.frame_payload[63:56] ^= 8'h10;
    pending_items_q.push_back(it);
    pending_items_q.push_back(plain_item(crs_pkg::OP_TICK, '0, 1'b0, 1'b0, 1'b0));

    wait_drained();
    if (mismatch_count == 0) begin
      $display("** can_rx_supervisor: PASSED **");
    end else begin
      $display("** can_rx_supervisor: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("** can_rx_supervisor: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/crs_pkg.sv
src/crs_front.sv
src/crs_queue.sv
src/crs_back.sv
src/can_rx_supervisor.sv
src/crs_checker.sv
sim/can_rx_supervisor_tb.sv
